// ----- hdl/hsc_pkg.sv -----
// ----------------------------------------------------------------------------
// hsc_pkg
// Shared widths and constants for the nine-point cross stencil block.
// ----------------------------------------------------------------------------
package hsc_pkg;
   localparam int HSC_MAX_EDGE = 1024;
   localparam int TEMP_W       = 24;
   localparam int WGT_W        = 16;
   localparam int PT_W         = 41;   // temperature, weight, air flag
   localparam int PROD_W       = 41;   // signed t * unsigned w
   localparam int ACC_W        = 45;   // sum of nine products
   localparam int MAG_W        = 44;   // magnitude of the product sum
   localparam int WSUM_W       = 20;   // sum of nine weights

   localparam logic [1:0] CSR_EDGE_SIZE = 2'd0;
   localparam logic [1:0] CSR_AIR_RATE  = 2'd1;
   localparam logic [1:0] CSR_COOL_TEMP = 2'd2;

   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } div_ctl_type;
endpackage

// ----- hdl/heat_stencil_cross9_stream.sv -----
// ----------------------------------------------------------------------------
// heat_stencil_cross9_stream
// Nine-point cross stencil over a raster-order grid with air cooling blend.
// Flow: a border item is taken and stored and gives no result. An interior item
// is read against the line store and written back, divided by the bit-serial
// divider (skipped when all weights are 0), blended and then registered out.
// A new item is taken only in the idle state, after the prior result is registered.
// Reset: synchronous; positions clear, registers take their defaults, and the
// line store is not cleared.
// ----------------------------------------------------------------------------
module heat_stencil_cross9_stream
   import hsc_pkg::*;
#(
   parameter int MAX_EDGE = HSC_MAX_EDGE
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // temperature[23:0], weight[39:24]
   input  logic        req_tuser,   // is_air
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // new_temperature[23:0], center_row[33:24],
                                    // center_col[43:34], zero fill
   output logic        rsp_tlast,   // frame_last
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_data
);
   localparam int AW  = $clog2(MAX_EDGE);
   localparam int MAW = AW + 2;
   localparam int NW  = (AW + 1 > 11) ? AW + 1 : 11;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_READ = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_BL1  = 3'd3;
   localparam logic [2:0] ST_BL2  = 3'd4;
   localparam logic [2:0] ST_FIN  = 3'd5;

   // Configuration registers.
   logic [10:0]       edge_ff;
   logic [15:0]       rate_ff;
   logic [TEMP_W-1:0] cool_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_ff <= 11'd1024;
         rate_ff <= 16'd3277;
         cool_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_EDGE_SIZE: edge_ff <= csr_data[10:0];
            CSR_AIR_RATE:  rate_ff <= csr_data[15:0];
            CSR_COOL_TEMP: cool_ff <= csr_data;
            default:       ;
         endcase
      end
   end
   assign csr_ready = 1'b1;

   // Edge size in use, clamped to the supported range.
   logic [NW-1:0] n_eff, n_m1, n_m3, r_ext, c_ext;
   always_comb begin
      if (NW'(edge_ff) < NW'(5)) begin
         n_eff = NW'(5);
      end else if (NW'(edge_ff) > NW'(MAX_EDGE)) begin
         n_eff = NW'(MAX_EDGE);
      end else begin
         n_eff = NW'(edge_ff);
      end
      n_m1 = n_eff - NW'(1);
      n_m3 = n_eff - NW'(3);
   end

   // Control and item registers.
   logic [2:0]        state_ff, state_in;
   logic [AW-1:0]     row_ff, col_ff;
   logic [AW-1:0]     r_ff, c_ff;
   logic [PT_W-1:0]   cur_ff;
   logic              last_ff;
   logic [3:0]        cnt_ff;
   logic [ACC_W-1:0]  stw_ff;
   logic [WSUM_W-1:0] sw_ff;
   logic [PROD_W-1:0] mul_ff;
   logic [TEMP_W-1:0] ctr_temp_ff;
   logic              ctr_air_ff;
   logic              neg_ff;
   logic              div_go_ff;
   logic [TEMP_W-1:0] avg_ff;
   logic [40:0]       p1_ff;
   logic [41:0]       p2_ff;
   logic              rsp_valid_ff;
   logic [47:0]       rsp_data_ff;
   logic              rsp_last_ff;

   logic              accept, interior;
   logic [PT_W-1:0]   in_pt;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign in_pt      = {req_tuser, req_tdata[39:24], req_tdata[23:0]};
   assign r_ext      = NW'(row_ff);
   assign c_ext      = NW'(col_ff);
   assign interior   = (r_ext >= NW'(4)) && (r_ext <= n_m1) &&
                       (c_ext >= NW'(2)) && (c_ext <= n_m3);

   // Line store accesses. The slot of row r holds row r-4 until it is
   // overwritten, so the current item is written only after all reads.
   logic            wr_en, rd_en;
   logic [MAW-1:0]  wr_addr, rd_addr;
   logic [PT_W-1:0] wr_data, rd_data;
   logic [1:0]      rd_slot;
   logic [AW-1:0]   rd_col;

   always_comb begin
      rd_slot = r_ff[1:0] + 2'd2;
      rd_col  = c_ff;
      case (cnt_ff)
         4'd0: begin rd_slot = r_ff[1:0] + 2'd2; rd_col = c_ff;         end
         4'd1: begin rd_slot = r_ff[1:0] + 2'd2; rd_col = c_ff - 1'b1;  end
         4'd2: begin rd_slot = r_ff[1:0] + 2'd2; rd_col = c_ff - 2'd2;  end
         4'd3: begin rd_slot = r_ff[1:0] + 2'd2; rd_col = c_ff + 1'b1;  end
         4'd4: begin rd_slot = r_ff[1:0] + 2'd2; rd_col = c_ff + 2'd2;  end
         4'd5: begin rd_slot = r_ff[1:0] + 2'd1; rd_col = c_ff;         end
         4'd6: begin rd_slot = r_ff[1:0];        rd_col = c_ff;         end
         4'd7: begin rd_slot = r_ff[1:0] + 2'd3; rd_col = c_ff;         end
         default: ;
      endcase
      rd_en   = (state_ff == ST_READ) && (cnt_ff < 4'd8);
      rd_addr = {rd_slot, rd_col};
      if (accept && !interior) begin
         wr_en   = 1'b1;
         wr_addr = {row_ff[1:0], col_ff};
         wr_data = in_pt;
      end else begin
         wr_en   = (state_ff == ST_READ) && (cnt_ff == 4'd8);
         wr_addr = {r_ff[1:0], c_ff};
         wr_data = cur_ff;
      end
   end

   hsc_line_mem #(
      .DEPTH (4 * MAX_EDGE),
      .AW    (MAW)
   ) u_line_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Divider on magnitudes; the sign is applied afterward.
   div_ctl_type      div_ctl;
   logic [MAG_W-1:0] div_quo, stw_mag;
   assign stw_mag = stw_ff[ACC_W-1] ? MAG_W'(-stw_ff) : MAG_W'(stw_ff);

   hsc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go_ff),
      .dividend (stw_mag),
      .divisor  (sw_ff),
      .ctl      (div_ctl),
      .quotient (div_quo)
   );

   // Final blend sum, rounded toward zero and saturated.
   logic signed [42:0] bl_sum, bl_adj;
   logic signed [26:0] bl_res;
   logic [TEMP_W-1:0]  res_sat;
   always_comb begin
      bl_sum = 43'(signed'(p1_ff)) + 43'(signed'(p2_ff));
      bl_adj = bl_sum[42] ? bl_sum + 43'sd65535 : bl_sum;
      bl_res = 27'(bl_adj >>> 16);
      if (!ctr_air_ff) begin
         res_sat = avg_ff;
      end else if (bl_res > 27'sd8388607) begin
         res_sat = 24'h7FFFFF;
      end else if (bl_res < -27'sd8388608) begin
         res_sat = 24'h800000;
      end else begin
         res_sat = bl_res[23:0];
      end
   end

   logic out_free;
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept && interior) state_in = ST_READ;
         ST_READ: if (cnt_ff == 4'd9) state_in = ST_DIV;
         ST_DIV:  if (sw_ff == '0 || div_ctl.done) state_in = ST_BL1;
         ST_BL1:  state_in = ST_BL2;
         ST_BL2:  state_in = ST_FIN;
         ST_FIN:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_ff       <= '0;
         col_ff       <= '0;
         cnt_ff       <= '0;
         div_go_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         div_go_ff <= (state_ff == ST_READ) && (cnt_ff == 4'd9) && (sw_ff != '0);
         if (accept) begin
            if (c_ext >= n_m1) begin
               col_ff <= '0;
               row_ff <= (r_ext >= n_m1) ? '0 : row_ff + 1'b1;
            end else begin
               col_ff <= col_ff + 1'b1;
            end
         end
         if (state_ff == ST_READ) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else begin
            cnt_ff <= '0;
         end
         if (state_ff == ST_FIN && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      // The current item starts both sums.
      if (accept) begin
         r_ff    <= row_ff;
         c_ff    <= col_ff;
         cur_ff  <= in_pt;
         last_ff <= (r_ext == n_m1) && (c_ext == n_m3);
         stw_ff  <= ACC_W'($signed(req_tdata[23:0]) * $signed({1'b0, req_tdata[39:24]}));
         sw_ff   <= WSUM_W'(req_tdata[39:24]);
      end
      if (state_ff == ST_READ) begin
         if (cnt_ff >= 4'd1 && cnt_ff <= 4'd8) begin
            mul_ff <= PROD_W'($signed(rd_data[23:0]) * $signed({1'b0, rd_data[39:24]}));
            sw_ff  <= sw_ff + WSUM_W'(rd_data[39:24]);
         end
         if (cnt_ff == 4'd1) begin
            ctr_temp_ff <= rd_data[23:0];
            ctr_air_ff  <= rd_data[40];
         end
         if (cnt_ff >= 4'd2) begin
            stw_ff <= stw_ff + ACC_W'(signed'(mul_ff));
         end
      end
      if (div_go_ff) begin
         neg_ff <= stw_ff[ACC_W-1];
      end
      if (state_ff == ST_DIV) begin
         if (sw_ff == '0) begin
            avg_ff <= ctr_temp_ff;
         end else if (div_ctl.done) begin
            avg_ff <= neg_ff ? TEMP_W'(-div_quo) : TEMP_W'(div_quo);
         end
      end
      if (state_ff == ST_BL1) begin
         p1_ff <= 41'($signed({1'b0, rate_ff}) * $signed(cool_ff));
      end
      if (state_ff == ST_BL2) begin
         p2_ff <= 42'($signed({1'b0, 17'(17'h10000 - {1'b0, rate_ff})}) * $signed(avg_ff));
      end
      if (state_ff == ST_FIN && out_free) begin
         rsp_data_ff <= {4'd0, 10'(c_ff), 10'(r_ff - 2'd2), res_sat};
         rsp_last_ff <= last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
endmodule

// ----- hdl/hsc_line_mem.sv -----
// ----------------------------------------------------------------------------
// hsc_line_mem
// Line store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hsc_line_mem
   import hsc_pkg::*;
#(
   parameter int DEPTH = 4 * HSC_MAX_EDGE,
   parameter int AW    = $clog2(4 * HSC_MAX_EDGE)
) (
   input  logic            clock,
   input  logic            wr_en,
   input  logic [AW-1:0]   wr_addr,
   input  logic [PT_W-1:0] wr_data,
   input  logic            rd_en,
   input  logic [AW-1:0]   rd_addr,
   output logic [PT_W-1:0] rd_data
);
   logic [PT_W-1:0] mem [DEPTH];
   logic [PT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- hdl/hsc_div.sv -----
// ----------------------------------------------------------------------------
// hsc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hsc_div
   import hsc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [MAG_W-1:0]  dividend,
   input  logic [WSUM_W-1:0] divisor,
   output div_ctl_type       ctl,
   output logic [MAG_W-1:0]  quotient
);
   localparam int CW = $clog2(MAG_W + 1);

   logic [MAG_W-1:0]  quo_ff, quo_in;
   logic [WSUM_W:0]   rem_ff, rem_in;
   logic [WSUM_W-1:0] dvs_ff;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in;
   logic [WSUM_W+1:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = '0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = CW'(MAG_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // Shift the next dividend bit into the partial remainder.
         trial = {rem_ff, quo_ff[MAG_W-1]} - {2'b00, dvs_ff};
         if (!trial[WSUM_W+1]) begin
            rem_in = trial[WSUM_W:0];
            quo_in = {quo_ff[MAG_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[WSUM_W-1:0], quo_ff[MAG_W-1]};
            quo_in = {quo_ff[MAG_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         dvs_ff <= divisor;
      end
   end

   assign ctl.start = start;
   assign ctl.busy  = busy_ff;
   assign ctl.done  = done_ff;
   assign quotient  = quo_ff;
endmodule

// ----- dv/hsc_checker.sv -----
// ----------------------------------------------------------------------------
// hsc_checker
// Watches the item, result and register channels of the cross stencil block,
// predicts each result from its own copy of the line stores and registers,
// and compares every result with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsc_checker
   import hsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,   // temperature[23:0], weight[39:24]
   input  logic        req_tuser,   // is_air
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,   // new_temperature[23:0], center_row[33:24],
                                    // center_col[43:34], zero fill
   input  logic        rsp_tlast,   // frame_last
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_data,
   output int          mismatches,
   output int          outstanding
);

   typedef struct {
      logic signed [TEMP_W-1:0] temp;
      logic [9:0]               row;
      logic [9:0]               col;
      logic                     last;
   } cell_result_type;

   cell_result_type          cooled_q[$];
   logic [PT_W-1:0]          row_mem [0:4*HSC_MAX_EDGE-1];
   logic [10:0]              edge_reg;
   logic [15:0]              rate_reg;
   logic signed [TEMP_W-1:0] cool_reg;
   int unsigned              row_pos;
   int unsigned              col_pos;

   function automatic logic [PT_W-1:0] mem_at(int unsigned row, int unsigned col);
      return row_mem[(row % 4) * HSC_MAX_EDGE + col];
   endfunction

   function automatic longint pt_temp(logic [PT_W-1:0] p);
      return longint'($signed(p[TEMP_W-1:0]));
   endfunction

   function automatic longint pt_wgt(logic [PT_W-1:0] p);
      return longint'(p[39:24]);
   endfunction

   // Advance one grid point: form the cross around (row-2, col) when that
   // center is interior, then store the point and move the raster position.
   function automatic void diffuse_point(logic [PT_W-1:0] cur);
      int unsigned     n;
      int unsigned     r;
      int unsigned     c;
      logic [PT_W-1:0] pts[9];
      longint          sw;
      longint          stw;
      longint          avg;
      longint          rate;
      cell_result_type res;
      n = (edge_reg < 5) ? 5 : (edge_reg > HSC_MAX_EDGE) ? HSC_MAX_EDGE : edge_reg;
      r = row_pos;
      c = col_pos;
      if (r >= 4 && r <= n - 1 && c >= 2 && c <= n - 3) begin
         pts[0] = mem_at(r - 2, c);
         pts[1] = mem_at(r - 2, c - 1);
         pts[2] = mem_at(r - 2, c - 2);
         pts[3] = mem_at(r - 2, c + 1);
         pts[4] = mem_at(r - 2, c + 2);
         pts[5] = mem_at(r - 3, c);
         pts[6] = mem_at(r - 4, c);
         pts[7] = mem_at(r - 1, c);
         pts[8] = cur;
         sw = 0;
         stw = 0;
         for (int k = 0; k < 9; k++) begin
            sw += pt_wgt(pts[k]);
            stw += pt_temp(pts[k]) * pt_wgt(pts[k]);
         end
         avg = (sw == 0) ? pt_temp(pts[0]) : stw / sw;
         if (pts[0][40]) begin
            rate = longint'(rate_reg);
            avg = (rate * longint'(cool_reg) + (65536 - rate) * avg) / 65536;
         end
         if (avg > 8388607) avg = 8388607;
         if (avg < -8388608) avg = -8388608;
         res.temp = avg[TEMP_W-1:0];
         res.row = 10'(r - 2);
         res.col = 10'(c);
         res.last = (r == n - 1 && c == n - 3);
         cooled_q.push_back(res);
      end
      row_mem[(r % 4) * HSC_MAX_EDGE + c] = cur;
      if (c >= n - 1) begin
         col_pos = 0;
         row_pos = (r >= n - 1) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
   endfunction

   initial mismatches = 0;

   always @(posedge clock) begin
      cell_result_type want;
      if (reset) begin
         edge_reg = 11'd1024;
         rate_reg = 16'd3277;
         cool_reg = '0;
         row_pos = 0;
         col_pos = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (cooled_q.size() == 0) begin
               $error("unexpected result item: row %0d col %0d",
                      rsp_tdata[33:24], rsp_tdata[43:34]);
               mismatches++;
            end else begin
               want = cooled_q.pop_front();
               if (rsp_tdata[23:0] !== want.temp) begin
                  $error("new_temperature mismatch: expected %0d, actual %0d",
                         want.temp, $signed(rsp_tdata[23:0]));
                  mismatches++;
               end
               if (rsp_tdata[33:24] !== want.row) begin
                  $error("center_row mismatch: expected %0d, actual %0d",
                         want.row, rsp_tdata[33:24]);
                  mismatches++;
               end
               if (rsp_tdata[43:34] !== want.col) begin
                  $error("center_col mismatch: expected %0d, actual %0d",
                         want.col, rsp_tdata[43:34]);
                  mismatches++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("frame_last mismatch: expected %0d, actual %0d",
                         want.last, rsp_tlast);
                  mismatches++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_EDGE_SIZE: edge_reg = csr_data[10:0];
               CSR_AIR_RATE:  rate_reg = csr_data[15:0];
               CSR_COOL_TEMP: cool_reg = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            diffuse_point({req_tuser, req_tdata[39:0]});
      end
      outstanding <= cooled_q.size();
   end

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the nine-point cross stencil block: directed grid
// passes with extreme values, then random small grids under varied registers
// and handshake stalls; the checker beside the block scores every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import hsc_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   // Settle time after the last result we expect, so that the block is idle
   // before register writes.
   localparam int SETTLE = 120;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_EDGE_SIZE;
   logic [23:0] csr_data = '0;

   int          mismatches;
   int          outstanding;
   int          sent = 0;
   int          send_idle_pct = 14;
   int          recv_idle_pct = 62;
   int unsigned cycles = 0;

   heat_stencil_cross9_stream i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   hsc_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always #5 clock = ~clock;

   // The receiver stalls at random with the current idle share, redrawn on
   // every cycle so that stalls fall at varied points of the block's work.
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   // Watchdog for a hung block.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // The idle shares follow the number of items sent: first the receiver
   // stalls often, then the sender gaps often, and at the end nobody idles.
   task automatic update_idling();
      if (sent < 300) begin
         send_idle_pct = 14;
         recv_idle_pct = 62;
      end else if (sent < 600) begin
         send_idle_pct = 62;
         recv_idle_pct = 14;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   endtask

   // Send one grid point. A gap, when drawn, lowers tvalid before the item;
   // back-to-back items keep tvalid high without toggling it.
   task automatic send_point(logic [23:0] temp, logic [15:0] wgt, logic air);
      update_idling();
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {wgt, temp};
      req_tuser  <= air;
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   // Hold the sender until every expected result is out, then let any item
   // that gives no result drain from the block.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Register writes only happen with the block idle.
   task automatic csr_write(logic [1:0] idx, logic [23:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [23:0] rand_temp();
      case ($urandom_range(9))
         0:       return 24'h7FFFFF;
         1:       return 24'h800000;
         2:       return 24'($urandom_range(511)) - 24'd256;
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] rand_wgt(int unsigned style);
      case (style)
         0:       return 16'($urandom);
         1:       return 16'($urandom_range(600));
         2:       return 16'h0000;
         default: return ($urandom_range(2) == 0) ? 16'h0000 :
                         ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom);
      endcase
   endfunction

   // One full raster pass of an n x n grid with random content; the weight
   // style decides how often the whole cross has zero weight.
   task automatic random_pass(int unsigned n);
      int unsigned style;
      int unsigned air_pct;
      style = $urandom_range(3);
      air_pct = $urandom_range(100);
      for (int unsigned k = 0; k < n * n; k++)
         send_point(rand_temp(), rand_wgt(style), $urandom_range(99) < air_pct);
   endtask

   initial begin
      int unsigned n;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Smallest grid with extreme values: full-scale temperatures of both
      // signs, full and zero weights, and air cells cooled at the largest
      // rate toward the most negative air temperature.
      csr_write(CSR_EDGE_SIZE, 24'd5);
      csr_write(CSR_AIR_RATE, 24'hFFFF);
      csr_write(CSR_COOL_TEMP, 24'h800000);
      for (int r = 0; r < 5; r++)
         for (int c = 0; c < 5; c++)
            send_point(((r + c) % 2) ? 24'h7FFFFF : 24'h800000,
                       (r == 2 && c != 2) ? 16'h0000 : 16'hFFFF, (r + c) % 3 == 0);

      // A cross whose weights are all zero hands back the center, then the
      // blend toward the warmest air at zero rate leaves it as is.
      csr_write(CSR_AIR_RATE, 24'h0000);
      csr_write(CSR_COOL_TEMP, 24'h7FFFFF);
      for (int k = 0; k < 25; k++)
         send_point(rand_temp(), 16'h0000, 1'b1);

      // Shrink the grid in the middle of a pass: ten columns for three and a
      // part rows, then six, so the current row ends early and the pass
      // realigns at the next wrap.
      csr_write(CSR_EDGE_SIZE, 24'd10);
      csr_write(CSR_AIR_RATE, 24'd3277);
      for (int k = 0; k < 34; k++)
         send_point(rand_temp(), rand_wgt(0), $urandom_range(1));
      csr_write(CSR_EDGE_SIZE, 24'd6);
      for (int k = 0; k < 14; k++)
         send_point(rand_temp(), rand_wgt(0), $urandom_range(1));

      // Edge sizes below the range act as five; a value above the range is
      // written and then replaced before any item flows.
      csr_write(CSR_EDGE_SIZE, 24'd0);
      random_pass(5);
      csr_write(CSR_EDGE_SIZE, 24'd2047);
      csr_write(CSR_EDGE_SIZE, 24'd4);
      random_pass(5);

      // Random passes over mostly small grids with fresh registers each time.
      // A grid that would run far past the item budget falls back to five.
      while (sent < 875) begin
         case ($urandom_range(19))
            0:       n = 24 + $urandom_range(16);
            1, 2, 3: n = 10 + $urandom_range(6);
            default: n = 5 + $urandom_range(4);
         endcase
         if (sent + n * n > 900) n = 5;
         csr_write(CSR_EDGE_SIZE, 24'(n));
         case ($urandom_range(3))
            0:       csr_write(CSR_AIR_RATE, 24'h0000);
            1:       csr_write(CSR_AIR_RATE, 24'hFFFF);
            default: csr_write(CSR_AIR_RATE, 24'($urandom_range(65535)));
         endcase
         csr_write(CSR_COOL_TEMP, rand_temp());
         random_pass(n);
      end

      drain();
      if (mismatches == 0 && outstanding == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hdl/hsc_pkg.sv
hdl/hsc_line_mem.sv
hdl/hsc_div.sv
hdl/heat_stencil_cross9_stream.sv
dv/hsc_checker.sv
dv/tb_top.sv
